FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define LSE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lse assertion failed");

// next-cycle implication built on the clocked form
`define LSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	`LSE_ASSERT(lbl, clk, rst_n, (pre) |=> (post))

`endif

FILE: hw/rtl/lse_pkg.sv
// types, codes and constants of the lsb steganography extractor
package lse_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int VALUE_W      = 32;
	localparam int KIND_W       = 2;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int HEADER_BYTES = 4;

	localparam logic [7:0] MARK_ONE  = 8'hFF;
	localparam logic [7:0] MARK_ZERO = 8'hFE;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BITS_CODE    = 3'd0,
		REG_SAMPLE_BYTES = 3'd1,
		REG_BIG_ENDIAN   = 3'd2,
		REG_EXPECT_EXT   = 3'd3,
		REG_CARRIER_LEN  = 3'd4
	} reg_addr_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EXT     = 2'd1,
		KIND_LEN     = 2'd2,
		KIND_LEN_ERR = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_EXT     = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [2:0]         bits_code;
		logic [2:0]         sample_bytes;
		logic               big_endian;
		logic               expect_extension;
		logic [VALUE_W-1:0] carrier_length;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} result_t;

endpackage

FILE: hw/rtl/lse_if.sv
// handshake interfaces for sample, result and configuration channels
interface lse_in_if;
	import lse_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                start_req;
	modport source (output valid, sample, start_req, input ready);
	modport sink (input valid, sample, start_req, output ready);
endinterface

interface lse_out_if;
	import lse_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;
	logic               last;
	modport source (output valid, kind, value, last, input ready);
	modport sink (input valid, kind, value, last, output ready);
endinterface

interface lse_cfg_if;
	import lse_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: hw/rtl/lse_cfg_regs.sv
// configuration register file of the extractor
module lse_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	lse_cfg_if.sink      cfg,
	output lse_pkg::cfg_t regs
);
	import lse_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bits_code        <= 3'd1;
			regs_q.sample_bytes     <= 3'd1;
			regs_q.big_endian       <= 1'b0;
			regs_q.expect_extension <= 1'b1;
			regs_q.carrier_length   <= '1;
		end else if (cfg.valid) begin
			case (reg_addr_t'(cfg.addr))
				REG_BITS_CODE:    regs_q.bits_code        <= cfg.data[2:0];
				REG_SAMPLE_BYTES: regs_q.sample_bytes     <= cfg.data[2:0];
				REG_BIG_ENDIAN:   regs_q.big_endian       <= cfg.data[0];
				REG_EXPECT_EXT:   regs_q.expect_extension <= cfg.data[0];
				REG_CARRIER_LEN:  regs_q.carrier_length   <= cfg.data[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/lse_extract.sv
// bit collection, header decode and phase control for one item per cycle while step is high
module lse_extract (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lse_pkg::cfg_t                cfg,
	input  logic                         step,
	input  logic [lse_pkg::SAMPLE_W-1:0] sample,
	input  logic                         start_req,
	output logic                         res_valid,
	output lse_pkg::result_t             res
);
	import lse_pkg::*;

	logic [2:0]         bit_pos_q, bit_pos_b, bit_pos_n;
	logic [7:0]         acc_q, acc_b, acc_n;
	logic [VALUE_W-1:0] cnt_q, cnt_b, cnt_n, cnt_inc;
	logic [VALUE_W-1:0] plen_q, plen_b, plen_n, plen_hdr;
	phase_t             phase_q, phase_b, phase_n;

	logic       enhanced;
	logic [2:0] nm;
	logic [3:0] n4;
	logic [1:0] sb_sel;
	logic [7:0] target;
	logic [7:0] mask8;
	logic [2:0] bp_al;
	logic [3:0] bp_nx;
	logic [3:0] sh;
	logic [7:0] acc_nx;
	logic       skip;

	always_comb begin
		enhanced = (cfg.bits_code == 3'd0);
		case (cfg.bits_code)
			3'd0, 3'd1: nm = 3'd0;
			3'd2:       nm = 3'd1;
			3'd3:       nm = 3'd3;
			default:    nm = 3'd7;
		endcase
		n4 = {1'b0, nm} + 4'd1;

		if (enhanced || cfg.sample_bytes <= 3'd1) begin
			sb_sel = 2'd0;
		end else if (cfg.sample_bytes >= 3'd4) begin
			sb_sel = 2'd3;
		end else begin
			sb_sel = 2'(cfg.sample_bytes - 3'd1);
		end
		target = cfg.big_endian ? sample[{sb_sel, 3'b000} +: 8] : sample[7:0];

		// restart applies before the item is used
		bit_pos_b = start_req ? 3'd0 : bit_pos_q;
		acc_b     = start_req ? 8'd0 : acc_q;
		cnt_b     = start_req ? '0 : cnt_q;
		plen_b    = start_req ? '0 : plen_q;
		phase_b   = start_req ? PH_HEADER : phase_q;

		mask8  = 8'((9'h001 << n4) - 9'h001);
		bp_al  = bit_pos_b & ~nm;
		bp_nx  = {1'b0, bp_al} + n4;
		sh     = 4'd8 - bp_nx;
		acc_nx = acc_b | 8'({8'h00, target & mask8} << sh);

		cnt_inc  = cnt_b + 32'd1;
		plen_hdr = {plen_b[VALUE_W-9:0], acc_nx};

		skip = (phase_b == PH_DONE) ||
			(enhanced && target != MARK_ONE && target != MARK_ZERO);

		bit_pos_n = bit_pos_b;
		acc_n     = acc_b;
		cnt_n     = cnt_b;
		plen_n    = plen_b;
		phase_n   = phase_b;
		res_valid = 1'b0;
		res.kind  = KIND_PAYLOAD;
		res.value = {{(VALUE_W-8){1'b0}}, acc_nx};
		res.last  = 1'b0;

		if (!skip) begin
			if (!bp_nx[3]) begin
				bit_pos_n = bp_nx[2:0];
				acc_n     = acc_nx;
			end else begin
				bit_pos_n = 3'd0;
				acc_n     = 8'd0;
				case (phase_b)
					PH_HEADER: begin
						plen_n = plen_hdr;
						if (cnt_inc < VALUE_W'(HEADER_BYTES)) begin
							cnt_n = cnt_inc;
						end else begin
							cnt_n     = '0;
							res_valid = 1'b1;
							res.value = plen_hdr;
							if (plen_hdr > cfg.carrier_length) begin
								phase_n  = PH_DONE;
								res.kind = KIND_LEN_ERR;
								res.last = 1'b1;
							end else begin
								res.kind = KIND_LEN;
								if (plen_hdr != '0) begin
									phase_n = PH_PAYLOAD;
								end else if (cfg.expect_extension) begin
									phase_n = PH_EXT;
								end else begin
									phase_n  = PH_DONE;
									res.last = 1'b1;
								end
							end
						end
					end
					PH_PAYLOAD: begin
						cnt_n     = cnt_inc;
						res_valid = 1'b1;
						res.kind  = KIND_PAYLOAD;
						if (!(cnt_inc < plen_b)) begin
							if (cfg.expect_extension) begin
								phase_n = PH_EXT;
							end else begin
								phase_n  = PH_DONE;
								res.last = 1'b1;
							end
						end
					end
					PH_EXT: begin
						res_valid = 1'b1;
						res.kind  = KIND_EXT;
						if (acc_nx == 8'd0) begin
							phase_n  = PH_DONE;
							res.last = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (!step) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= 3'd0;
			acc_q     <= 8'd0;
			cnt_q     <= '0;
			plen_q    <= '0;
			phase_q   <= PH_HEADER;
		end else if (step) begin
			bit_pos_q <= bit_pos_n;
			acc_q     <= acc_n;
			cnt_q     <= cnt_n;
			plen_q    <= plen_n;
			phase_q   <= phase_n;
		end
	end

endmodule

FILE: hw/rtl/lsb_steg_extractor_unit.sv
// top level of the lsb steganography extractor
//
// channel  dir  payload                         accepted when
// smp      in   sample[31:0], start_req         smp.valid && smp.ready
// res      out  kind[1:0], value[31:0], last    res.valid && res.ready
// cfg      in   addr[2:0], data[31:0]           cfg.valid && cfg.ready
//
// one item per cycle sustained while res.ready does not stall the result register
// items pass an input register, then the extract logic writes the result register
// smp.ready drops only while the input register holds an item and the result register
// is stalled by res.ready; cfg.ready is always high
// reset restores the register defaults and the header phase
module lsb_steg_extractor_unit (
	input  logic      clk,
	input  logic      arst_n,
	lse_in_if.sink    smp,
	lse_out_if.source res,
	lse_cfg_if.sink   cfg
);
	import lse_pkg::*;

	cfg_t                regs;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                start_s1;
	logic                adv;
	logic                step;
	logic                step_res_valid;
	result_t             step_res;
	logic                res_valid_q;
	result_t             res_q;

	lse_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign adv       = !res_valid_q || res.ready;
	assign step      = valid_s1 && adv;
	assign smp.ready = !valid_s1 || adv;

	lse_extract u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs),
		.step      (step),
		.sample    (sample_s1),
		.start_req (start_s1),
		.res_valid (step_res_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.ready) begin
			valid_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.ready && smp.valid) begin
			sample_s1 <= smp.sample;
			start_s1  <= smp.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= step && step_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && step_res_valid) begin
			res_q <= step_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.kind  = res_q.kind;
	assign res.value = res_q.value;
	assign res.last  = res_q.last;

endmodule

FILE: hw/rtl/lse_checker.sv
// port-level assertions of the extractor and their bind
`include "assert_macros.svh"

module lse_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [lse_pkg::KIND_W-1:0]  res_kind,
	input logic [lse_pkg::VALUE_W-1:0] res_value,
	input logic                        res_last
);
	import lse_pkg::*;

	`LSE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_value) && $stable(res_last))
	`LSE_ASSERT(a_byte_range, clk, arst_n, (res_valid && (res_kind == KIND_PAYLOAD || res_kind == KIND_EXT)) |-> (res_value[VALUE_W-1:8] == '0))
	`LSE_ASSERT(a_ext_term, clk, arst_n, (res_valid && res_kind == KIND_EXT) |-> ((res_value == '0) == res_last))
	`LSE_ASSERT(a_err_last, clk, arst_n, (res_valid && res_kind == KIND_LEN_ERR) |-> res_last)

endmodule

bind lsb_steg_extractor_unit lse_checker u_lse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.kind),
	.res_value (res.value),
	.res_last  (res.last)
);

FILE: dv/lsb_steg_extractor_unit_tb.sv
// testbench for the lsb steganography extractor: random carriers checked by a bit-level predictor
`timescale 1ns / 1ps

module lsb_steg_extractor_unit_tb;
	import lse_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE       = 6;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 118;

	typedef logic [7:0] octets_t[$];

	class lsb_extract_scoreboard;
		cfg_t       cfg;
		phase_t     stage;
		logic [2:0] bit_pos;
		logic [7:0] acc;
		logic [31:0] byte_cnt;
		logic [31:0] pay_len;
		result_t    decoded_q[$];
		int         mismatch_count;

		function new();
			cfg.bits_code = 3'd1;
			cfg.sample_bytes = 3'd1;
			cfg.big_endian = 1'b0;
			cfg.expect_extension = 1'b1;
			cfg.carrier_length = 32'hFFFFFFFF;
			mismatch_count = 0;
			restart();
		endfunction

		function void restart();
			bit_pos = 0;
			acc = 0;
			byte_cnt = 0;
			pay_len = 0;
			stage = PH_HEADER;
		endfunction

		function void write_reg(reg_addr_t a, logic [31:0] d);
			case (a)
				REG_BITS_CODE: cfg.bits_code = d[2:0];
				REG_SAMPLE_BYTES: cfg.sample_bytes = d[2:0];
				REG_BIG_ENDIAN: cfg.big_endian = d[0];
				REG_EXPECT_EXT: cfg.expect_extension = d[0];
				REG_CARRIER_LEN: cfg.carrier_length = d;
				default: ;
			endcase
		endfunction

		function int chunk_bits();
			if (cfg.bits_code == 3'd0)
				return 1;
			if (cfg.bits_code >= 3'd4)
				return 8;
			return 1 << (cfg.bits_code - 1);
		endfunction

		function int carrier_lane();
			int sb;
			sb = (cfg.sample_bytes == 3'd0) ? 1 : ((cfg.sample_bytes > 3'd4) ? 4 : cfg.sample_bytes);
			if (cfg.bits_code == 3'd0)
				sb = 1;
			return cfg.big_endian ? sb - 1 : 0;
		endfunction

		function void queue_result(kind_t k, logic [31:0] v, logic l);
			result_t r;
			r.kind = k;
			r.value = v;
			r.last = l;
			decoded_q.push_back(r);
		endfunction

		function void note_sample(logic [31:0] s, bit st);
			int n, bp;
			logic [7:0] tgt, data, mask, done_byte;
			n = chunk_bits();
			if (st)
				restart();
			if (stage == PH_DONE)
				return;
			tgt = s[8*carrier_lane() +: 8];
			if (cfg.bits_code == 3'd0 && tgt != MARK_ONE && tgt != MARK_ZERO)
				return;
			mask = 8'((1 << n) - 1);
			data = tgt & mask;
			bp = int'(bit_pos) & ~(n - 1);
			acc = acc | (data << (8 - bp - n));
			bp += n;
			if (bp < 8) begin
				bit_pos = 3'(bp);
				return;
			end
			bit_pos = 0;
			done_byte = acc;
			acc = 0;
			case (stage)
				PH_HEADER: begin
					pay_len = {pay_len[23:0], done_byte};
					byte_cnt++;
					if (byte_cnt < HEADER_BYTES)
						return;
					byte_cnt = 0;
					if (pay_len > cfg.carrier_length) begin
						stage = PH_DONE;
						queue_result(KIND_LEN_ERR, pay_len, 1'b1);
					end else if (pay_len != 0) begin
						stage = PH_PAYLOAD;
						queue_result(KIND_LEN, pay_len, 1'b0);
					end else if (cfg.expect_extension) begin
						stage = PH_EXT;
						queue_result(KIND_LEN, pay_len, 1'b0);
					end else begin
						stage = PH_DONE;
						queue_result(KIND_LEN, pay_len, 1'b1);
					end
				end
				PH_PAYLOAD: begin
					byte_cnt++;
					if (byte_cnt < pay_len) begin
						queue_result(KIND_PAYLOAD, {24'd0, done_byte}, 1'b0);
					end else if (cfg.expect_extension) begin
						stage = PH_EXT;
						queue_result(KIND_PAYLOAD, {24'd0, done_byte}, 1'b0);
					end else begin
						stage = PH_DONE;
						queue_result(KIND_PAYLOAD, {24'd0, done_byte}, 1'b1);
					end
				end
				default: begin
					if (done_byte == 8'd0) begin
						stage = PH_DONE;
						queue_result(KIND_EXT, 32'd0, 1'b1);
					end else begin
						queue_result(KIND_EXT, {24'd0, done_byte}, 1'b0);
					end
				end
			endcase
		endfunction

		function void check_result(logic [1:0] k, logic [31:0] v, logic l);
			result_t want;
			if (decoded_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d value %h last %b",
					$time, k, v, l);
				return;
			end
			want = decoded_q.pop_front();
			if (want.kind !== k) begin
				mismatch_count++;
				$display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
			end
			if (want.value !== v) begin
				mismatch_count++;
				$display("%0t: value expected %h actual %h", $time, want.value, v);
			end
			if (want.last !== l) begin
				mismatch_count++;
				$display("%0t: last expected %b actual %b", $time, want.last, l);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lse_in_if  smp_if();
	lse_out_if res_if();
	lse_cfg_if cfg_if();

	lsb_extract_scoreboard model = new();

	bit steady;
	bit hold_req;
	int hold_left;
	int stall_left;
	int cycle_count;
	int items_sent;

	lsb_steg_extractor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("lsb_steg_extractor_unit: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			model.check_result(res_if.kind, res_if.value, res_if.last);
	end

	// result side back-pressure
	initial begin
		res_if.ready = 1'b0;
		hold_left = 0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready = 1'b0;
			end else begin
				res_if.ready = 1'b1;
				if (!steady && $urandom_range(0, 99) < 20)
					stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
			end
		end
	end

	function automatic int gap_cycles();
		int r;
		if (steady || hold_req || hold_left > 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input logic [31:0] s, input bit st);
		int gap;
		@(negedge clk);
		smp_if.valid = 1'b1;
		smp_if.sample = s;
		smp_if.start_req = st;
		do @(posedge clk); while (!smp_if.ready);
		model.note_sample(s, st);
		items_sent++;
		gap = gap_cycles();
		repeat (gap) begin
			@(negedge clk);
			smp_if.valid = 1'b0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		smp_if.valid = 1'b0;
		while (model.decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_addr_t a, input logic [31:0] d);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.addr = a;
		cfg_if.data = d;
		do @(posedge clk); while (!cfg_if.ready);
		model.write_reg(a, d);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic configure(input logic [2:0] bits, input logic [2:0] sb, input bit be,
		input bit ext, input logic [31:0] cap);
		write_reg(REG_BITS_CODE, {29'd0, bits});
		write_reg(REG_SAMPLE_BYTES, {29'd0, sb});
		write_reg(REG_BIG_ENDIAN, {31'd0, be});
		write_reg(REG_EXPECT_EXT, {31'd0, ext});
		write_reg(REG_CARRIER_LEN, cap);
	endtask

	// spreads bytes msb-first over the carrier lane of successive samples
	task automatic send_stream(input octets_t msg, input bit with_start);
		int n, lane, pos;
		logic [31:0] s;
		logic [7:0] mask, chunk;
		bit st;
		n = model.chunk_bits();
		lane = model.carrier_lane();
		mask = 8'((1 << n) - 1);
		st = with_start;
		foreach (msg[i]) begin
			for (pos = 0; pos < 8; pos += n) begin
				chunk = (msg[i] >> (8 - pos - n)) & mask;
				s = $urandom;
				if (model.cfg.bits_code == 3'd0) begin
					// samples that are neither mark are skipped
					while ($urandom_range(0, 3) == 0) begin
						s[7:0] = 8'($urandom_range(0, 8'hFD));
						send_item(s, st);
						st = 1'b0;
						s = $urandom;
					end
					s[7:0] = chunk[0] ? MARK_ONE : MARK_ZERO;
				end else begin
					s[8*lane +: 8] = (s[8*lane +: 8] & ~mask) | chunk;
				end
				send_item(s, st);
				st = 1'b0;
			end
		end
	endtask

	task automatic send_noise(input int count);
		repeat (count)
			send_item($urandom, $urandom_range(0, 7) == 0);
	endtask

	task automatic send_carrier(input bit truncate);
		octets_t msg;
		logic [31:0] cap, len;
		int r, cut;
		cap = model.cfg.carrier_length;
		r = $urandom_range(0, 99);
		if (r < 12 && cap != 32'hFFFFFFFF) begin
			len = ($urandom_range(0, 1) == 1) ? cap + 1
				: cap + 1 + ($urandom % (32'hFFFFFFFF - cap));
		end else if (r < 22) begin
			len = 0;
		end else begin
			len = (r < 27) ? $urandom_range(12, 24) : $urandom_range(1, 8);
			if (len > cap)
				len = $urandom_range(0, cap);
		end
		msg = '{len[31:24], len[23:16], len[15:8], len[7:0]};
		if (len <= cap) begin
			repeat (len) msg.push_back(8'($urandom));
			if (model.cfg.expect_extension) begin
				repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(1, 255)));
				msg.push_back(8'd0);
			end
		end
		if (truncate) begin
			cut = $urandom_range(1, msg.size() - 1);
			while (msg.size() > cut)
				void'(msg.pop_back());
		end
		send_stream(msg, 1'b1);
	endtask

	initial begin
		octets_t msg;
		int phase_idx, phase_start, r;
		logic [31:0] cap;
		arst_n = 1'b0;
		smp_if.valid = 1'b0;
		smp_if.sample = '0;
		smp_if.start_req = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.addr = REG_BITS_CODE;
		cfg_if.data = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		cycle_count = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole bytes per sample, carrier in the last lane
		configure(3'd4, 3'd4, 1'b1, 1'b1, 32'd3);
		msg = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h80, 8'h00};
		send_stream(msg, 1'b1);
		send_item($urandom, 1'b0);
		msg = '{8'h00, 8'h00, 8'h00, 8'h04};
		send_stream(msg, 1'b1);
		send_item($urandom, 1'b0);
		drain();
		// zero length and payload end without extension
		configure(3'd4, 3'd1, 1'b0, 1'b0, 32'd0);
		msg = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_stream(msg, 1'b1);
		drain();
		write_reg(REG_CARRIER_LEN, 32'hFFFFFFFF);
		msg = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hA5};
		send_stream(msg, 1'b1);

		for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
			drain();
			case (phase_idx % 4)
				0: cap = 32'hFFFFFFFF;
				1: cap = 32'd0;
				2: cap = $urandom_range(0, 20);
				default: cap = $urandom;
			endcase
			configure(3'(phase_idx), 3'(phase_idx * 3), 1'($urandom_range(0, 1)),
				phase_idx[1], cap);
			steady = (phase_idx % 5 == 4);
			if (phase_idx == 6)
				hold_req = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					send_carrier(1'b0);
				end else if (r < 85) begin
					send_carrier(1'b1);
				end else if (r < 93) begin
					send_noise($urandom_range(1, 6));
				end else begin
					// continue without restart, possibly mid byte
					msg.delete();
					repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
					send_stream(msg, 1'b0);
				end
			end
			// leave a partial byte behind for the next setting
			repeat ($urandom_range(0, 3)) send_item($urandom, 1'b0);
			steady = 1'b0;
		end

		drain();
		if (model.mismatch_count == 0)
			$display("lsb_steg_extractor_unit: match");
		else
			$display("lsb_steg_extractor_unit: mismatch");
		$finish;
	end

endmodule

FILE: lsb_steg_extractor_unit.f
+incdir+hw/rtl
hw/rtl/lse_pkg.sv
hw/rtl/lse_if.sv
hw/rtl/lse_cfg_regs.sv
hw/rtl/lse_extract.sv
hw/rtl/lsb_steg_extractor_unit.sv
hw/rtl/lse_checker.sv
dv/lsb_steg_extractor_unit_tb.sv
